### sv/mag_cal_sample_collector_macros.svh
// Assertion macros for the magnetometer calibration sample collector.
`ifndef MAG_CAL_SAMPLE_COLLECTOR_MACROS_SVH
`define MAG_CAL_SAMPLE_COLLECTOR_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define MCSC_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition must hold in the cycle after the trigger
`define MCSC_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

### sv/mcsc_pkg.sv
// Shared types, constants and helper functions of the sample collector.
package mcsc_pkg;

	// trailing zero bits of a constant
	function automatic int ctz(input int v);
		int n;
		n = 0;
		while (n < 31 && v[n] == 1'b0)
			n++;
		return n;
	endfunction

	// sizing
	localparam int NUM_SAMPLES = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int FIELD_BITS  = 16;
	localparam int CNT_W       = $clog2(NUM_SAMPLES + 1);
	localparam int SQ_W        = 2 * SAMPLE_BITS;
	localparam int D2_W        = 2 * SAMPLE_BITS + 2;

	// threshold divider: ceil(16*r2 / (9*N))
	localparam int DIV_D  = 9 * NUM_SAMPLES;
	localparam int DIV_W  = 2 * SAMPLE_BITS + 6;

	// divisor split into a power of two (a shift) and an odd part, which is
	// taken by multiplying with a rounded-up reciprocal; exact for every
	// NDIV_W-bit numerator since the rounding error stays below 2^RECIP_L
	localparam int DIV_SHIFT   = ctz(DIV_D);
	localparam int DIV_ODD     = DIV_D >> DIV_SHIFT;
	localparam int NDIV_W      = DIV_W - DIV_SHIFT;
	localparam int RECIP_L     = $clog2(DIV_ODD);
	localparam int RECIP_SHIFT = NDIV_W + RECIP_L;
	localparam int RECIP_W     = NDIV_W + 1;
	localparam int PROD_W      = NDIV_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_ODD =
		RECIP_W'(((128'd1 << RECIP_SHIFT) + 128'(DIV_ODD - 1)) / 128'(DIV_ODD));

	// status codes
	localparam logic [1:0] STAT_ACCEPTED  = 2'd0;
	localparam logic [1:0] STAT_TOO_CLOSE = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SQ,
		FSM_SUM,
		FSM_DIV,
		FSM_SCAN
	} fsm_t;

	// input word
	typedef struct packed {
		logic signed [FIELD_BITS-1:0] mag_x;
		logic signed [FIELD_BITS-1:0] mag_y;
		logic signed [FIELD_BITS-1:0] mag_z;
	} sample_t;

	// result word
	typedef struct packed {
		logic [1:0] status;
		logic [6:0] stored_count;
		logic       store_full;
	} result_t;

	// sample at internal width
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x;
		logic signed [SAMPLE_BITS-1:0] y;
		logic signed [SAMPLE_BITS-1:0] z;
	} vec_t;

	// probe token handed from cell to cell
	typedef struct packed {
		logic             valid;
		logic             reject;
		logic [CNT_W-1:0] left;
		vec_t             smp;
	} token_t;

	// low SAMPLE_BITS of a field; bits above the field read as zero
	function automatic logic signed [SAMPLE_BITS-1:0] take_sample(
		input logic [FIELD_BITS-1:0] v);
		logic [FIELD_BITS+SAMPLE_BITS-1:0] wide;
		wide = {{SAMPLE_BITS{1'b0}}, v};
		return wide[SAMPLE_BITS-1:0];
	endfunction

	// square of a signed difference, one multiplier
	function automatic logic [SQ_W-1:0] sq_mag(input logic signed [SAMPLE_BITS:0] d);
		logic [SAMPLE_BITS:0] m;
		logic [SQ_W-1:0]      a;
		m = d[SAMPLE_BITS] ? (~d + 1'b1) : d;
		a = SQ_W'(m[SAMPLE_BITS-1:0]);
		return a * a;
	endfunction

	function automatic vec_t to_vec(input sample_t s);
		vec_t v;
		v.x = take_sample(s.mag_x);
		v.y = take_sample(s.mag_y);
		v.z = take_sample(s.mag_z);
		return v;
	endfunction

endpackage

### sv/mcsc_cdiv.sv
// Divider by the constant 9*NUM_SAMPLES: shift, then reciprocal multiply, both registered.
module mcsc_cdiv (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mcsc_pkg::DIV_W-1:0]   dividend,
	output logic                         done,
	output logic [mcsc_pkg::DIV_W-1:0]   quotient
);

	logic [mcsc_pkg::NDIV_W-1:0] num_s1;
	logic                        vld_s1;
	logic [mcsc_pkg::PROD_W-1:0] prod;
	logic [mcsc_pkg::DIV_W-1:0]  quot_q;
	logic                        done_q;

	// numerator times the rounded-up reciprocal of the odd part
	assign prod = mcsc_pkg::PROD_W'(num_s1) * mcsc_pkg::PROD_W'(mcsc_pkg::RECIP_ODD);

	// stage valid and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			done_q <= vld_s1;
		end
	end

	// power-of-two part drops off as a shift, then the product is scaled down
	always_ff @(posedge clk) begin
		if (start)
			num_s1 <= dividend[mcsc_pkg::DIV_W-1:mcsc_pkg::DIV_SHIFT];
		if (vld_s1)
			quot_q <= mcsc_pkg::DIV_W'(prod[mcsc_pkg::PROD_W-1:mcsc_pkg::RECIP_SHIFT]);
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

### sv/mcsc_cell.sv
// One storage cell: holds a stored sample and tests the passing probe against it.
module mcsc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mcsc_pkg::token_t            tok_i,
	input  logic                        wr_en,
	input  mcsc_pkg::vec_t              wr_smp,
	input  logic [mcsc_pkg::D2_W-1:0]   thr,
	output mcsc_pkg::token_t            tok_o
);

	mcsc_pkg::vec_t              smp_q;
	logic                        valid_q;
	logic                        reject_q;
	logic [mcsc_pkg::CNT_W-1:0]  left_q;
	mcsc_pkg::vec_t              psmp_q;
	logic                        live;
	logic [mcsc_pkg::SQ_W-1:0]   sqx, sqy, sqz;
	logic [mcsc_pkg::D2_W-1:0]   d2;
	logic                        too_close;

	// squared distance probe to stored sample
	always_comb begin
		live = tok_i.valid && (tok_i.left != '0);
		sqx  = mcsc_pkg::sq_mag({tok_i.smp.x[mcsc_pkg::SAMPLE_BITS-1], tok_i.smp.x}
		                      - {smp_q.x[mcsc_pkg::SAMPLE_BITS-1], smp_q.x});
		sqy  = mcsc_pkg::sq_mag({tok_i.smp.y[mcsc_pkg::SAMPLE_BITS-1], tok_i.smp.y}
		                      - {smp_q.y[mcsc_pkg::SAMPLE_BITS-1], smp_q.y});
		sqz  = mcsc_pkg::sq_mag({tok_i.smp.z[mcsc_pkg::SAMPLE_BITS-1], tok_i.smp.z}
		                      - {smp_q.z[mcsc_pkg::SAMPLE_BITS-1], smp_q.z});
		d2   = mcsc_pkg::D2_W'(sqx) + mcsc_pkg::D2_W'(sqy) + mcsc_pkg::D2_W'(sqz);
		too_close = live && (d2 < thr);
	end

	// stored sample
	always_ff @(posedge clk) begin
		if (wr_en)
			smp_q <= wr_smp;
	end

	// token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= tok_i.valid;
	end

	// token payload; left counts the stored cells still ahead
	always_ff @(posedge clk) begin
		reject_q <= tok_i.reject | too_close;
		left_q   <= (tok_i.left != '0) ? tok_i.left - 1'b1 : tok_i.left;
		psmp_q   <= tok_i.smp;
	end

	always_comb begin
		tok_o.valid  = valid_q;
		tok_o.reject = reject_q;
		tok_o.left   = left_q;
		tok_o.smp    = psmp_q;
	end

endmodule

### sv/mag_cal_sample_collector.sv
// Top level of the magnetometer calibration sample collector.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+-------------------------------------
//  input    | sample (sample_t)     | word taken when start && !busy
//  output   | result (result_t)     | done high for one cycle per word
//
// A later sample strobes done once its probe has walked the whole row of cells,
// one cell per cycle. The first sample passes squares, sum, then the two-stage
// reciprocal divider for the threshold before its strobe. A full store answers
// next cycle. busy drops in the strobe cycle, so the next word can be taken at
// its end. Reset clears the count, the threshold and the cell tokens; stored
// samples are not cleared. The receiver cannot stall: done is a one-cycle strobe.
`include "mag_cal_sample_collector_macros.svh"

module mag_cal_sample_collector (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  mcsc_pkg::sample_t sample,
	output logic              done,
	output mcsc_pkg::result_t result
);

	mcsc_pkg::fsm_t              state_q, state_d;
	logic [mcsc_pkg::CNT_W-1:0]  count_q, cnt_nx;
	logic [mcsc_pkg::D2_W-1:0]   thr_q;
	mcsc_pkg::vec_t              smp_q;
	logic [mcsc_pkg::SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
	logic [mcsc_pkg::D2_W-1:0]   r2;
	logic                        done_q;
	mcsc_pkg::result_t           res_q;

	logic                        accept;
	logic                        is_full;
	logic                        div_start;
	logic                        div_done;
	logic [mcsc_pkg::DIV_W-1:0]  quotient;
	logic                        inject;
	logic                        commit;
	logic                        finish;
	logic [1:0]                  fin_status;

	mcsc_pkg::token_t            chain [mcsc_pkg::NUM_SAMPLES+1];
	logic [mcsc_pkg::NUM_SAMPLES:0] tok_vld;

	assign accept  = start && !busy;
	assign is_full = (count_q == mcsc_pkg::CNT_W'(mcsc_pkg::NUM_SAMPLES));
	assign busy    = (state_q != mcsc_pkg::FSM_IDLE);
	assign cnt_nx  = count_q + mcsc_pkg::CNT_W'(commit);

	// probe enters the first cell straight from the input word
	always_comb begin
		chain[0].valid  = inject;
		chain[0].reject = 1'b0;
		chain[0].left   = count_q;
		chain[0].smp    = mcsc_pkg::to_vec(sample);
	end

	// row of cells
	for (genvar i = 0; i < mcsc_pkg::NUM_SAMPLES; i++) begin : g_cell
		mcsc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (chain[i]),
			.wr_en  (commit && (count_q == mcsc_pkg::CNT_W'(i))),
			.wr_smp (smp_q),
			.thr    (thr_q),
			.tok_o  (chain[i+1])
		);
	end

	for (genvar j = 0; j <= mcsc_pkg::NUM_SAMPLES; j++) begin : g_vld
		assign tok_vld[j] = chain[j].valid;
	end

	// reference magnitude and threshold divider
	assign r2 = mcsc_pkg::D2_W'(sqx_q) + mcsc_pkg::D2_W'(sqy_q) + mcsc_pkg::D2_W'(sqz_q);

	mcsc_cdiv u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ((mcsc_pkg::DIV_W'(r2) << 4) + mcsc_pkg::DIV_W'(mcsc_pkg::DIV_D - 1)),
		.done     (div_done),
		.quotient (quotient)
	);

	// sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		inject     = 1'b0;
		commit     = 1'b0;
		finish     = 1'b0;
		fin_status = mcsc_pkg::STAT_ACCEPTED;
		case (state_q)
			mcsc_pkg::FSM_IDLE: begin
				if (accept) begin
					if (is_full) begin
						finish     = 1'b1;
						fin_status = mcsc_pkg::STAT_FULL;
					end else if (count_q == '0) begin
						state_d = mcsc_pkg::FSM_SQ;
					end else begin
						inject  = 1'b1;
						state_d = mcsc_pkg::FSM_SCAN;
					end
				end
			end
			mcsc_pkg::FSM_SQ: begin
				state_d = mcsc_pkg::FSM_SUM;
			end
			mcsc_pkg::FSM_SUM: begin
				div_start = 1'b1;
				state_d   = mcsc_pkg::FSM_DIV;
			end
			mcsc_pkg::FSM_DIV: begin
				if (div_done) begin
					commit  = 1'b1;
					finish  = 1'b1;
					state_d = mcsc_pkg::FSM_IDLE;
				end
			end
			mcsc_pkg::FSM_SCAN: begin
				if (chain[mcsc_pkg::NUM_SAMPLES].valid) begin
					finish  = 1'b1;
					state_d = mcsc_pkg::FSM_IDLE;
					if (chain[mcsc_pkg::NUM_SAMPLES].reject)
						fin_status = mcsc_pkg::STAT_TOO_CLOSE;
					else
						commit = 1'b1;
				end
			end
			default: begin
				state_d = mcsc_pkg::FSM_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcsc_pkg::FSM_IDLE;
			count_q <= '0;
			thr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= cnt_nx;
			done_q  <= finish;
			if (state_q == mcsc_pkg::FSM_DIV && div_done)
				thr_q <= mcsc_pkg::D2_W'(quotient);
		end
	end

	// word latch, reference squares and result word
	always_ff @(posedge clk) begin
		if (accept)
			smp_q <= mcsc_pkg::to_vec(sample);
		if (state_q == mcsc_pkg::FSM_SQ) begin
			sqx_q <= mcsc_pkg::sq_mag({smp_q.x[mcsc_pkg::SAMPLE_BITS-1], smp_q.x});
			sqy_q <= mcsc_pkg::sq_mag({smp_q.y[mcsc_pkg::SAMPLE_BITS-1], smp_q.y});
			sqz_q <= mcsc_pkg::sq_mag({smp_q.z[mcsc_pkg::SAMPLE_BITS-1], smp_q.z});
		end
		if (finish) begin
			res_q.status       <= fin_status;
			res_q.stored_count <= 7'(cnt_nx);
			res_q.store_full   <= (cnt_nx == mcsc_pkg::CNT_W'(mcsc_pkg::NUM_SAMPLES));
		end
	end

	assign done   = done_q;
	assign result = res_q;

	// checks
	`MCSC_ASSERT_NOW(a_count_range, 1'b1, count_q <= mcsc_pkg::CNT_W'(mcsc_pkg::NUM_SAMPLES), "sample count beyond store size")
	`MCSC_ASSERT_NOW(a_one_probe, 1'b1, $countones(tok_vld) <= 1, "more than one probe in the cell row")
	`MCSC_ASSERT_NEXT(a_commit_count, commit, count_q == $past(count_q) + 1'b1, "stored count did not advance on store")
	`MCSC_ASSERT_NEXT(a_full_ignored, accept && is_full, done && result.status == mcsc_pkg::STAT_FULL, "word on full store not reported as ignored")

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench of the magnetometer calibration sample collector.
`timescale 1ns / 100ps

module tb_top;
	import mcsc_pkg::*;

	localparam int RUN_LIMIT  = 400_000;
	localparam int RAND_WORDS = 430;
	localparam int FAR_PCT    = 10;
	// per-axis jitter around a kept sample; spacing limit with the first sample below is 1000
	localparam int NEAR_SPAN  = 700;

	// Tracks the kept samples and predicts the verdict word for each sample word
	class collector_checker;
		logic signed [15:0] kept [NUM_SAMPLES][3];
		int unsigned        kept_cnt;
		longint             min_d2;
		result_t            verdicts_due [$];
		int unsigned        mismatches;

		function new();
			kept_cnt   = 0;
			min_d2     = 0;
			mismatches = 0;
		endfunction

		// spacing test against every kept sample, first sample sets the limit
		function void log_sample(sample_t s);
			logic signed [15:0] v [3];
			longint             diff;
			longint             d2;
			bit                 close;
			result_t            r;
			v[0] = s.mag_x;
			v[1] = s.mag_y;
			v[2] = s.mag_z;
			close = 1'b0;
			if (kept_cnt >= NUM_SAMPLES) begin
				r.status = STAT_FULL;
			end else begin
				if (kept_cnt == 0) begin
					d2 = 0;
					for (int k = 0; k < 3; k++) begin
						diff = v[k];
						d2 += diff * diff;
					end
					// ceil(16*r2 / (9*N))
					min_d2 = (16 * d2 + 9 * NUM_SAMPLES - 1) / (9 * NUM_SAMPLES);
				end else begin
					for (int i = 0; i < kept_cnt && !close; i++) begin
						d2 = 0;
						for (int k = 0; k < 3; k++) begin
							diff = v[k] - kept[i][k];
							d2 += diff * diff;
						end
						if (d2 < min_d2)
							close = 1'b1;
					end
				end
				if (close) begin
					r.status = STAT_TOO_CLOSE;
				end else begin
					for (int k = 0; k < 3; k++)
						kept[kept_cnt][k] = v[k];
					kept_cnt++;
					r.status = STAT_ACCEPTED;
				end
			end
			r.stored_count = 7'(kept_cnt);
			r.store_full   = (kept_cnt == NUM_SAMPLES);
			verdicts_due.push_back(r);
		endfunction

		// compare one result word with the oldest prediction
		function void check_word(result_t got);
			result_t want;
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result word with nothing expected: %p", $realtime, got);
				return;
			end
			want = verdicts_due.pop_front();
			if (got.status !== want.status || got.stored_count !== want.stored_count ||
					got.store_full !== want.store_full) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch status %0d/%0d count %0d/%0d full %0d/%0d (exp/act)",
						$realtime, want.status, got.status, want.stored_count,
						got.stored_count, want.store_full, got.store_full);
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	sample_t sample;
	logic    done;
	result_t result;

	collector_checker chk = new();
	int unsigned      words_in = 0;
	int               idle_pct;
	int               cycle_cnt = 0;

	mag_cal_sample_collector dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sample (sample),
		.done   (done),
		.result (result)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// monitor: accepted sample words and result strobes
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				chk.log_sample(sample);
				words_in++;
			end
			if (done)
				chk.check_word(result);
		end
	end

	// present one word after a random gap, return at the falling edge after it is taken
	task automatic send_word(sample_t s);
		int          gap;
		int unsigned seen;
		gap = 0;
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seen = words_in;
		start  <= 1'b1;
		sample <= s;
		do @(negedge clk); while (words_in == seen);
	endtask

	task automatic send_xyz(int x, int y, int z);
		sample_t s;
		s.mag_x = 16'(x);
		s.mag_y = 16'(y);
		s.mag_z = 16'(z);
		send_word(s);
	endtask

	// full-range sample, or one jittered around a kept sample
	function automatic sample_t pick_sample(bit far);
		sample_t     s;
		int          c [3];
		int unsigned idx;
		if (far || chk.kept_cnt == 0) begin
			s.mag_x = 16'($urandom);
			s.mag_y = 16'($urandom);
			s.mag_z = 16'($urandom);
		end else begin
			idx = $urandom_range(0, chk.kept_cnt - 1);
			for (int k = 0; k < 3; k++) begin
				c[k] = $urandom_range(0, 2 * NEAR_SPAN);
				c[k] = c[k] - NEAR_SPAN + chk.kept[idx][k];
				if (c[k] > 32767)
					c[k] = 32767;
				else if (c[k] < -32768)
					c[k] = -32768;
			end
			s.mag_x = 16'(c[0]);
			s.mag_y = 16'(c[1]);
			s.mag_z = 16'(c[2]);
		end
		return s;
	endfunction

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		sample   = '0;
		idle_pct = 6;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// first sample: r2 = 36e6, spacing limit d2 >= 1e6
		send_xyz(6000, 0, 0);
		send_xyz(6000, 0, 0);          // duplicate, too close
		send_xyz(5001, 0, 0);          // just inside the limit
		send_xyz(7000, 0, 0);          // exactly on the limit, kept
		send_xyz(6000, 0, 1000);       // on the limit along another axis
		send_xyz(6000, 999, 0);        // just inside
		send_xyz(0, 0, 0);
		send_xyz(-1, -1, -1);          // next to the origin
		send_xyz(32767, 32767, 32767);
		send_xyz(-32768, -32768, -32768);
		send_xyz(-32768, 32767, -32768);
		send_xyz(32767, -32768, 32767);
		send_xyz(0, -32768, 0);
		send_xyz(0, 32767, 0);
		send_xyz(32767, 32767, 32766); // close to a corner sample

		// random words, mostly jittered around kept samples
		for (int n = 0; n < RAND_WORDS && chk.kept_cnt < NUM_SAMPLES; n++) begin
			idle_pct = (n < 150) ? 6 : (n < 300) ? 52 : 0;
			send_word(pick_sample($urandom_range(0, 99) < FAR_PCT));
		end
		// fill the store, then a few words on a full store
		idle_pct = 0;
		while (chk.kept_cnt < NUM_SAMPLES)
			send_word(pick_sample(1'b1));
		idle_pct = 30;
		repeat (12)
			send_word(pick_sample($urandom_range(0, 3) == 0));
		start <= 1'b0;

		while (chk.verdicts_due.size() != 0)
			@(posedge clk);
		repeat (NUM_SAMPLES + 8) @(posedge clk);
		if (chk.mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/mcsc_pkg.sv
sv/mcsc_cdiv.sv
sv/mcsc_cell.sv
sv/mag_cal_sample_collector.sv
tb/sv/tb_top.sv
